[hw/rtl/lhps_pkg.sv]
// Shared types and constants for the LED / haptic pattern sequencer.
// No dependencies; imported by every module of the block.
package lhps_pkg;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_SET   = 2'd1,
      REQ_PULSE = 2'd2
   } lhps_req_type;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_TRAIN    = 3'd1,
      MODE_CHARGING = 3'd2,
      MODE_ZONE     = 3'd3,
      MODE_HOLD     = 3'd4,
      MODE_DONE     = 3'd5,
      MODE_CALIB    = 3'd6,
      MODE_BATT_LOW = 3'd7
   } lhps_mode_type;

   localparam logic [1:0] CSR_IDLE_FLASH = 2'd0;
   localparam logic [1:0] CSR_IDLE_DARK  = 2'd1;
   localparam logic [1:0] CSR_LOW_BATT   = 2'd2;
   localparam logic [1:0] CSR_STRENGTH   = 2'd3;

   localparam logic [15:0] IDLE_FLASH_RST = 16'd80;
   localparam logic [15:0] IDLE_DARK_RST  = 16'd1920;
   localparam logic [15:0] LOW_BATT_RST   = 16'd150;
   localparam logic [7:0]  STRENGTH_RST   = 8'd200;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_ms;
      logic [2:0]  pattern;
      logic [15:0] pulse_count;
      logic [15:0] pulse_on_ms;
      logic [15:0] pulse_off_ms;
   } lhps_item_type;

   typedef struct packed {
      logic [15:0] idle_flash_ms;
      logic [15:0] idle_dark_ms;
      logic [15:0] low_battery_half_ms;
      logic [7:0]  vib_strength;
   } lhps_cfg_type;

   typedef struct packed {
      logic        start;
      logic [15:0] count;
      logic [15:0] on_ms;
      logic [15:0] off_ms;
   } lhps_train_type;

   // Preset vibration trains started by some set-pattern items.
   function automatic lhps_train_type lhps_preset(input lhps_mode_type mode);
      lhps_train_type t;
      t = '0;
      unique case (mode)
         MODE_ZONE:  t = '{start: 1'b1, count: 16'd1, on_ms: 16'd80,  off_ms: 16'd0};
         MODE_HOLD:  t = '{start: 1'b1, count: 16'd2, on_ms: 16'd120, off_ms: 16'd100};
         MODE_DONE:  t = '{start: 1'b1, count: 16'd3, on_ms: 16'd400, off_ms: 16'd200};
         MODE_CALIB: t = '{start: 1'b1, count: 16'd2, on_ms: 16'd100, off_ms: 16'd80};
         default:    t = '0;
      endcase
      return t;
   endfunction

endpackage

[hw/rtl/led_haptic_pattern_sequencer.sv]
// Top level of the LED / haptic pattern sequencer: input register, CSRs,
// result register. Depends on lhps_pkg, lhps_led and lhps_vib.
//
//   port group | direction | flow control
//   req_*      | in        | req_valid / req_stall
//   rsp_*      | out       | rsp_valid / rsp_stall
//   csr_*      | in        | csr_write, no back-pressure
//
// One item per cycle unless stalled; rsp_valid is set as the result register loads.
// The state update (32-bit adds and compares in each unit) sits between the
// input register and the result register and happens as the item moves on.
// Synchronous reset clears state and both valid bits and loads the CSR defaults.
// rsp_stall holds the result register; the input register still takes one
// more item, and req_stall rises only when both are full.
module led_haptic_pattern_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_now_ms,
   input  logic [2:0]  req_pattern,
   input  logic [15:0] req_pulse_count,
   input  logic [15:0] req_pulse_on_ms,
   input  logic [15:0] req_pulse_off_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_led_on,
   output logic        rsp_vib_on,
   output logic [7:0]  rsp_vib_duty,
   output logic [15:0] rsp_pulses_left,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import lhps_pkg::*;

   lhps_cfg_type  cfg_ff;
   logic          in_valid_ff;
   lhps_item_type item_ff;
   logic          advance;
   logic          led_level_in;
   logic          vib_level_in;
   logic [15:0]   remaining_in;
   logic          rsp_valid_ff;
   logic          led_on_ff;
   logic          vib_on_ff;
   logic [7:0]    vib_duty_ff;
   logic [15:0]   pulses_left_ff;

   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{idle_flash_ms: IDLE_FLASH_RST, idle_dark_ms: IDLE_DARK_RST,
                     low_battery_half_ms: LOW_BATT_RST, vib_strength: STRENGTH_RST};
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IDLE_FLASH: cfg_ff.idle_flash_ms       <= csr_wdata;
            CSR_IDLE_DARK:  cfg_ff.idle_dark_ms        <= csr_wdata;
            CSR_LOW_BATT:   cfg_ff.low_battery_half_ms <= csr_wdata;
            CSR_STRENGTH:   cfg_ff.vib_strength        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (~req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & ~req_stall) begin
         item_ff <= '{kind: req_type, now_ms: req_now_ms, pattern: req_pattern,
                      pulse_count: req_pulse_count, pulse_on_ms: req_pulse_on_ms,
                      pulse_off_ms: req_pulse_off_ms};
      end
   end

   lhps_led u_led (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .item         (item_ff),
      .cfg          (cfg_ff),
      .led_level_in (led_level_in)
   );

   lhps_vib u_vib (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .item         (item_ff),
      .vib_level_in (vib_level_in),
      .remaining_in (remaining_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         led_on_ff      <= led_level_in;
         vib_on_ff      <= vib_level_in;
         vib_duty_ff    <= vib_level_in ? cfg_ff.vib_strength : 8'd0;
         pulses_left_ff <= remaining_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led_on      = led_on_ff;
   assign rsp_vib_on      = vib_on_ff;
   assign rsp_vib_duty    = vib_duty_ff;
   assign rsp_pulses_left = pulses_left_ff;

   a_duty_off : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_vib_on) |-> (rsp_vib_duty == 8'd0))
      else $error("duty nonzero with motor off");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while pipeline has room");

   a_moves_on : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff) |=> rsp_valid)
      else $error("item did not reach result register");

endmodule

[hw/rtl/lhps_led.sv]
// LED pattern state: mode, LED level and blink deadline.
// Depends on lhps_pkg.
module lhps_led (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  lhps_pkg::lhps_item_type item,
   input  lhps_pkg::lhps_cfg_type  cfg,
   output logic                   led_level_in
);
   import lhps_pkg::*;

   lhps_mode_type mode_ff, mode_in;
   logic          led_level_ff;
   logic [31:0]   deadline_ff, deadline_in;
   logic          due;
   logic          flip;
   logic [15:0]   addend;
   logic [31:0]   sum;
   lhps_mode_type new_mode;

   assign due      = item.now_ms >= deadline_ff;
   assign flip     = ~led_level_ff;
   assign addend   = (mode_ff == MODE_IDLE) ? (flip ? cfg.idle_flash_ms : cfg.idle_dark_ms)
                                            : cfg.low_battery_half_ms;
   assign sum      = item.now_ms + {16'd0, addend};
   assign new_mode = lhps_mode_type'(item.pattern);

   always_comb begin
      mode_in      = mode_ff;
      led_level_in = led_level_ff;
      deadline_in  = deadline_ff;
      if (step) begin
         unique case (lhps_req_type'(item.kind))
            REQ_TICK: begin
               if ((mode_ff == MODE_IDLE || mode_ff == MODE_BATT_LOW) && due) begin
                  led_level_in = flip;
                  deadline_in  = sum;
               end
            end
            REQ_SET: begin
               mode_in = new_mode;
               if (new_mode == MODE_TRAIN) begin
                  led_level_in = 1'b1;
               end else if (new_mode == MODE_CHARGING) begin
                  led_level_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         led_level_ff <= 1'b0;
         deadline_ff  <= '0;
      end else begin
         mode_ff      <= mode_in;
         led_level_ff <= led_level_in;
         deadline_ff  <= deadline_in;
      end
   end

endmodule

[hw/rtl/lhps_vib.sv]
// Vibration pulse-train state: level, remaining count, times, deadline.
// Depends on lhps_pkg.
module lhps_vib (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  lhps_pkg::lhps_item_type item,
   output logic                   vib_level_in,
   output logic [15:0]            remaining_in
);
   import lhps_pkg::*;

   logic           level_ff;
   logic [15:0]    remaining_ff;
   logic [15:0]    on_time_ff, on_time_in;
   logic [15:0]    off_time_ff, off_time_in;
   logic [31:0]    deadline_ff, deadline_in;
   logic           pending_ff, pending_in;
   logic [31:0]    sum_on, sum_off, eff_deadline;
   logic [15:0]    rem_dec;
   logic           due;
   lhps_train_type preset;

   assign sum_on       = item.now_ms + {16'd0, on_time_ff};
   assign sum_off      = item.now_ms + {16'd0, off_time_ff};
   // first tick after a train starts takes its deadline from that tick
   assign eff_deadline = pending_ff ? sum_on : deadline_ff;
   assign due          = item.now_ms >= eff_deadline;
   assign rem_dec      = remaining_ff - 16'd1;
   assign preset       = lhps_preset(lhps_mode_type'(item.pattern));

   always_comb begin
      vib_level_in = level_ff;
      remaining_in = remaining_ff;
      on_time_in   = on_time_ff;
      off_time_in  = off_time_ff;
      deadline_in  = deadline_ff;
      pending_in   = pending_ff;
      if (step) begin
         unique case (lhps_req_type'(item.kind))
            REQ_TICK: begin
               if (remaining_ff != 16'd0) begin
                  pending_in   = 1'b0;
                  deadline_in  = eff_deadline;
                  vib_level_in = level_ff | pending_ff;
                  if (due) begin
                     if (level_ff | pending_ff) begin
                        vib_level_in = 1'b0;
                        remaining_in = rem_dec;
                        if (rem_dec != 16'd0) begin
                           deadline_in = sum_off;
                        end
                     end else begin
                        vib_level_in = 1'b1;
                        deadline_in  = sum_on;
                     end
                  end
               end
            end
            REQ_SET: begin
               if (preset.start) begin
                  remaining_in = preset.count;
                  on_time_in   = preset.on_ms;
                  off_time_in  = preset.off_ms;
                  vib_level_in = 1'b1;
                  pending_in   = 1'b1;
               end
            end
            REQ_PULSE: begin
               remaining_in = item.pulse_count;
               on_time_in   = item.pulse_on_ms;
               off_time_in  = item.pulse_off_ms;
               vib_level_in = 1'b1;
               pending_in   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= 1'b0;
         remaining_ff <= '0;
         on_time_ff   <= '0;
         off_time_ff  <= '0;
         deadline_ff  <= '0;
         pending_ff   <= 1'b0;
      end else begin
         level_ff     <= vib_level_in;
         remaining_ff <= remaining_in;
         on_time_ff   <= on_time_in;
         off_time_ff  <= off_time_in;
         deadline_ff  <= deadline_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

[sim/tb_top.sv]
// Self-checking bench for led_haptic_pattern_sequencer: a scoreboard with its own copy of
// the LED blink and vibration train state checks every result against the items sent.
// Depends on lhps_pkg and the block's RTL only.
module tb_top;
   import lhps_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic        led_on;
      logic        vib_on;
      logic [7:0]  vib_duty;
      logic [15:0] pulses_left;
   } drive_levels_type;

   class haptic_scoreboard_type;
      lhps_cfg_type  cfg;
      lhps_mode_type mode;
      bit            led_level;
      logic [31:0]   led_deadline;
      bit            vib_level;
      logic [15:0]   vib_left;
      logic [15:0]   vib_on_ms;
      logic [15:0]   vib_off_ms;
      logic [31:0]   vib_deadline;
      bit            vib_start_pending;
      drive_levels_type expected_levels[$];
      int unsigned   mismatches;

      function new();
         cfg = '{idle_flash_ms: IDLE_FLASH_RST, idle_dark_ms: IDLE_DARK_RST,
                 low_battery_half_ms: LOW_BATT_RST, vib_strength: STRENGTH_RST};
         mode = MODE_IDLE;
         led_level = 1'b0;
         led_deadline = '0;
         vib_level = 1'b0;
         vib_left = '0;
         vib_on_ms = '0;
         vib_off_ms = '0;
         vib_deadline = '0;
         vib_start_pending = 1'b0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] value);
         case (idx)
            CSR_IDLE_FLASH: cfg.idle_flash_ms = value;
            CSR_IDLE_DARK:  cfg.idle_dark_ms = value;
            CSR_LOW_BATT:   cfg.low_battery_half_ms = value;
            CSR_STRENGTH:   cfg.vib_strength = value[7:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      function void start_train(logic [15:0] count, logic [15:0] on_ms, logic [15:0] off_ms);
         vib_left = count;
         vib_on_ms = on_ms;
         vib_off_ms = off_ms;
         vib_level = 1'b1;
         vib_start_pending = 1'b1;
      endfunction

      function void advance_to(logic [31:0] now);
         if (mode == MODE_IDLE) begin
            if (now >= led_deadline) begin
               led_level = !led_level;
               led_deadline = now + (led_level ? cfg.idle_flash_ms : cfg.idle_dark_ms);
            end
         end else if (mode == MODE_BATT_LOW) begin
            if (now >= led_deadline) begin
               led_level = !led_level;
               led_deadline = now + cfg.low_battery_half_ms;
            end
         end
         // a train with no pulses left is never stepped, so the motor holds its level
         if (vib_left != 0) begin
            if (vib_start_pending) begin
               vib_deadline = now + vib_on_ms;
               vib_level = 1'b1;
               vib_start_pending = 1'b0;
            end
            if (now >= vib_deadline) begin
               if (vib_level) begin
                  vib_level = 1'b0;
                  vib_left = vib_left - 16'd1;
                  if (vib_left != 0)
                     vib_deadline = now + vib_off_ms;
               end else begin
                  vib_level = 1'b1;
                  vib_deadline = now + vib_on_ms;
               end
            end
         end
      endfunction

      function void note_item(lhps_item_type it);
         drive_levels_type lv;
         if (it.kind == REQ_TICK) begin
            advance_to(it.now_ms);
         end else if (it.kind == REQ_SET) begin
            mode = lhps_mode_type'(it.pattern);
            case (mode)
               MODE_TRAIN:    led_level = 1'b1;
               MODE_CHARGING: led_level = 1'b0;
               MODE_ZONE:     start_train(16'd1, 16'd80, 16'd0);
               MODE_HOLD:     start_train(16'd2, 16'd120, 16'd100);
               MODE_DONE:     start_train(16'd3, 16'd400, 16'd200);
               MODE_CALIB:    start_train(16'd2, 16'd100, 16'd80);
               default: ;
            endcase
         end else if (it.kind == REQ_PULSE) begin
            start_train(it.pulse_count, it.pulse_on_ms, it.pulse_off_ms);
         end
         lv.led_on = led_level;
         lv.vib_on = vib_level;
         lv.vib_duty = vib_level ? cfg.vib_strength : 8'd0;
         lv.pulses_left = vib_left;
         expected_levels.push_back(lv);
      endfunction

      function void check_result(drive_levels_type got);
         drive_levels_type want;
         if (expected_levels.size() == 0) begin
            $error("result with no item outstanding");
            mismatches++;
            return;
         end
         want = expected_levels.pop_front();
         if (got.led_on !== want.led_on) begin
            $error("led_on: expected %0d, got %0d", want.led_on, got.led_on);
            mismatches++;
         end
         if (got.vib_on !== want.vib_on) begin
            $error("vib_on: expected %0d, got %0d", want.vib_on, got.vib_on);
            mismatches++;
         end
         if (got.vib_duty !== want.vib_duty) begin
            $error("vib_duty: expected %0d, got %0d", want.vib_duty, got.vib_duty);
            mismatches++;
         end
         if (got.pulses_left !== want.pulses_left) begin
            $error("pulses_left: expected %0d, got %0d", want.pulses_left, got.pulses_left);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_type;
   logic [31:0] req_now_ms;
   logic [2:0]  req_pattern;
   logic [15:0] req_pulse_count;
   logic [15:0] req_pulse_on_ms;
   logic [15:0] req_pulse_off_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_led_on;
   logic        rsp_vib_on;
   logic [7:0]  rsp_vib_duty;
   logic [15:0] rsp_pulses_left;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   haptic_scoreboard_type sb;
   int unsigned      gap_pct;
   int unsigned      stall_pct;
   logic [31:0]      ms_clock;

   led_haptic_pattern_sequencer u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_now_ms(req_now_ms),
      .req_pattern(req_pattern),
      .req_pulse_count(req_pulse_count),
      .req_pulse_on_ms(req_pulse_on_ms),
      .req_pulse_off_ms(req_pulse_off_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_led_on(rsp_led_on),
      .rsp_vib_on(rsp_vib_on),
      .rsp_vib_duty(rsp_vib_duty),
      .rsp_pulses_left(rsp_pulses_left),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic lhps_item_type build_item(logic [1:0] kind, logic [31:0] now,
                                                logic [2:0] pattern, logic [15:0] count,
                                                logic [15:0] on_ms, logic [15:0] off_ms);
      lhps_item_type it;
      it.kind = kind;
      it.now_ms = now;
      it.pattern = pattern;
      it.pulse_count = count;
      it.pulse_on_ms = on_ms;
      it.pulse_off_ms = off_ms;
      return it;
   endfunction

   function automatic logic [15:0] rand_count();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return 16'd0;
      if (r < 75) return 16'($urandom_range(1, 4));
      if (r < 90) return 16'($urandom_range(5, 20));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] rand_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return 16'd0;
      if (r < 85) return 16'($urandom_range(1, 200));
      return 16'($urandom);
   endfunction

   // mostly ticks moving forward in time, so blinks and trains run their course
   function automatic lhps_item_type rand_item();
      lhps_item_type it;
      int unsigned   sel;
      int unsigned   jump;
      sel = $urandom_range(0, 99);
      jump = $urandom_range(0, 99);
      it = build_item(REQ_TICK, $urandom(), 3'($urandom_range(0, 7)), rand_count(),
                      rand_span(), rand_span());
      if (sel < 78) begin
         if (jump < 50) ms_clock += $urandom_range(0, 60);
         else if (jump < 80) ms_clock += $urandom_range(0, 400);
         else if (jump < 93) ms_clock += $urandom_range(0, 2500);
         else if (jump < 97) ms_clock += $urandom_range(0, 70000);
         else if (jump < 99) ms_clock = $urandom();
         else ms_clock = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
         it.now_ms = ms_clock;
      end else if (sel < 88) begin
         it.kind = REQ_SET;
      end else if (sel < 97) begin
         it.kind = REQ_PULSE;
      end else begin
         it.kind = REQ_UNUSED;
      end
      return it;
   endfunction

   // entered at a falling edge; returns at the falling edge after the item is taken
   task automatic send_item(input lhps_item_type it);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_type = it.kind;
      req_now_ms = it.now_ms;
      req_pattern = it.pattern;
      req_pulse_count = it.pulse_count;
      req_pulse_on_ms = it.pulse_on_ms;
      req_pulse_off_ms = it.pulse_off_ms;
      do @(posedge clock); while (req_stall);
      sb.note_item(it);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic program_regs(input logic [15:0] flash, input logic [15:0] dark,
                               input logic [15:0] half, input logic [7:0] strength);
      logic [15:0] strength_word;
      strength_word = {8'($urandom), strength};
      csr_write = 1'b1;
      csr_index = CSR_IDLE_FLASH;
      csr_wdata = flash;
      @(negedge clock);
      csr_index = CSR_IDLE_DARK;
      csr_wdata = dark;
      @(negedge clock);
      csr_index = CSR_LOW_BATT;
      csr_wdata = half;
      @(negedge clock);
      csr_index = CSR_STRENGTH;
      csr_wdata = strength_word;
      @(negedge clock);
      csr_write = 1'b0;
      sb.set_reg(CSR_IDLE_FLASH, flash);
      sb.set_reg(CSR_IDLE_DARK, dark);
      sb.set_reg(CSR_LOW_BATT, half);
      sb.set_reg(CSR_STRENGTH, strength_word);
   endtask

   initial begin : rsp_side
      int unsigned hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_pct == 0) begin
            hold = 0;
            rsp_stall = 1'b0;
         end else if (hold != 0) begin
            hold--;
            rsp_stall = 1'b1;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            hold = $urandom_range(0, 9);
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(drive_levels_type'({rsp_led_on, rsp_vib_on, rsp_vib_duty,
                                             rsp_pulses_left}));
   end

   initial begin : stimulus
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_TICK;
      req_now_ms = '0;
      req_pattern = MODE_IDLE;
      req_pulse_count = '0;
      req_pulse_on_ms = '0;
      req_pulse_off_ms = '0;
      csr_write = 1'b0;
      csr_index = CSR_IDLE_FLASH;
      csr_wdata = '0;
      gap_pct = 20;
      stall_pct = 20;
      ms_clock = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // idle heartbeat from a zero deadline, just short of and at the flash end
      send_item(build_item(REQ_TICK, 32'd0, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_TICK, 32'd79, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_TICK, 32'd80, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_TICK, 32'hFFFF_FFFF, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      // zero-count train keeps the motor on
      send_item(build_item(REQ_PULSE, 32'd0, MODE_IDLE, 16'd0, 16'd30, 16'd30));
      send_item(build_item(REQ_TICK, 32'd5, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      // zero on time: first tick loads and expires the deadline together
      send_item(build_item(REQ_PULSE, 32'd0, MODE_IDLE, 16'd2, 16'd0, 16'd0));
      send_item(build_item(REQ_TICK, 32'd10, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_TICK, 32'd10, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_TICK, 32'd11, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_SET, 32'd0, MODE_TRAIN, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_SET, 32'd0, MODE_CHARGING, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_SET, 32'd0, MODE_ZONE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_TICK, 32'd100, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      // last pulse of the zone train
      send_item(build_item(REQ_TICK, 32'd180, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_SET, 32'd0, MODE_HOLD, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_SET, 32'd0, MODE_DONE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_SET, 32'd0, MODE_CALIB, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_SET, 32'd0, MODE_BATT_LOW, 16'd0, 16'd0, 16'd0));
      // deadlines wrap past 2^32 and come due at a small time
      send_item(build_item(REQ_TICK, 32'hFFFF_FFF0, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_TICK, 32'd200, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_SET, 32'd0, MODE_IDLE, 16'd0, 16'd0, 16'd0));
      send_item(build_item(REQ_UNUSED, 32'hFFFF_FFFF, MODE_BATT_LOW, 16'hFFFF, 16'hFFFF,
                           16'hFFFF));
      send_item(build_item(REQ_PULSE, 32'd0, MODE_IDLE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_item(build_item(REQ_TICK, 32'hFFFF_FFFF, MODE_IDLE, 16'd0, 16'd0, 16'd0));

      for (int ph = 0; ph < 5; ph++) begin
         if (ph != 0)
            drain();
         case (ph)
            1: begin
               program_regs(16'd0, 16'd0, 16'd0, 8'd0);
               gap_pct = 30;
               stall_pct = 10;
            end
            2: begin
               program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
               gap_pct = 10;
               stall_pct = 40;
            end
            3: begin
               program_regs(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
                            16'($urandom_range(1, 300)), 8'($urandom_range(1, 254)));
               gap_pct = 25;
               stall_pct = 25;
            end
            4: begin
               program_regs(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                            16'($urandom_range(0, 3000)), 8'($urandom));
               gap_pct = 0;
               stall_pct = 0;
            end
            default: ;
         endcase
         repeat (220) send_item(rand_item());
      end

      drain();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin : watchdog
      #6_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[led_haptic_pattern_sequencer.f]
hw/rtl/lhps_pkg.sv
hw/rtl/lhps_led.sv
hw/rtl/lhps_vib.sv
hw/rtl/led_haptic_pattern_sequencer.sv
sim/tb_top.sv
